[src/sos_pkg.sv]
`default_nettype none
package sos_pkg;

    // limits on the row width and on the number of counted rows
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 1024;

    // fixed field widths
    localparam int ROI_W      = 11;
    localparam int SPEED_W    = 12;
    localparam int GAIN_W     = 14;
    localparam int LEVEL_W    = 17;
    localparam int RATIO_W    = 17;
    localparam int ANG_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int CNT_W      = 21;

    // derived widths
    localparam int COL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int WCMP_W   = (COL_W > ROI_W) ? COL_W : ROI_W;
    localparam int AREA_W   = COL_W + ROW_W;
    localparam int DIV_W    = (CNT_W > AREA_W + 1) ? CNT_W : AREA_W + 1;
    localparam int STEP_W   = $clog2(RATIO_W + 1);
    localparam int DIFF_W   = RATIO_W + 1;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam int STEER_SH = 18;
    localparam int STEER_W  = PROD_W - STEER_SH;

    // floor(w / 3) as (w * 2731) >> 13, exact for w up to 4096
    localparam int DIV3_MUL = 2731;
    localparam int DIV3_SH  = 13;
    localparam int DIV3_P_W = COL_W + 12;

    localparam logic [CNT_W-1:0]   CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_FULL     = RATIO_W'(1 << 16);
    localparam logic [LEVEL_W:0]   MIN_STOP_LEVEL = (LEVEL_W + 1)'(655);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CRAWL_SPEED   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_STOP   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_SLOW     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_MARGIN  = CFG_IDX_W'(7);

    // register reset values
    localparam logic [ROI_W-1:0]   RST_ROI_WIDTH     = ROI_W'(486);
    localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = SPEED_W'(82);
    localparam logic [SPEED_W-1:0] RST_CRAWL_SPEED   = SPEED_W'(41);
    localparam logic [SPEED_W-1:0] RST_YAW_LIMIT     = SPEED_W'(461);
    localparam logic [GAIN_W-1:0]  RST_STEER_GAIN    = GAIN_W'(1434);
    localparam logic [LEVEL_W-1:0] RST_CENTER_STOP   = LEVEL_W'(11796);
    localparam logic [LEVEL_W-1:0] RST_SIDE_SLOW     = LEVEL_W'(15729);
    localparam logic [LEVEL_W-1:0] RST_CLEAR_MARGIN  = LEVEL_W'(2621);

    typedef logic [1:0] sector_t;
    localparam sector_t SEC_LEFT   = 2'd0;
    localparam sector_t SEC_CENTER = 2'd1;
    localparam sector_t SEC_RIGHT  = 2'd2;

    typedef struct packed {
        logic    accept;
        logic    load_area;
        logic    div_start;
        logic    store_ratio;
        logic    decide;
        logic    finish;
        sector_t sector;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

[src/sos_div.sv]
`default_nettype none
module sos_div (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire [sos_pkg::CNT_W-1:0]      count,
    input  wire [sos_pkg::AREA_W-1:0]     area,
    output logic                          done,
    output logic [sos_pkg::RATIO_W-1:0]   quot
);
    import sos_pkg::*;

    // restoring division of (count << 16) by area, one quotient bit a cycle
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [AREA_W-1:0]   dvs_reg, dvs_next;
    logic [RATIO_W-1:0]  q_reg, q_next;
    logic [RATIO_W-1:0]  quot_reg, quot_next;
    logic                lsb_reg, lsb_next;
    logic                zero_reg, zero_next;
    logic                ovf_reg, ovf_next;

    logic [DIV_W:0]      rem_shift;
    logic [DIV_W:0]      dvs_ext;
    logic                take;
    logic [RATIO_W-1:0]  q_step;

    always_comb begin
        rem_shift = {rem_reg, lsb_reg};
        dvs_ext   = (DIV_W + 1)'(dvs_reg);
        take      = rem_shift >= dvs_ext;
        q_step    = {q_reg[RATIO_W-2:0], take};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        lsb_next  = lsb_reg;
        zero_next = zero_reg;
        ovf_next  = ovf_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(RATIO_W);
            rem_next  = DIV_W'(count >> 1);
            lsb_next  = count[0];
            dvs_next  = area;
            q_next    = '0;
            zero_next = area == '0;
            ovf_next  = DIV_W'(count) >= DIV_W'({area, 1'b0});
        end else if (busy_reg) begin
            rem_next  = take ? DIV_W'(rem_shift - dvs_ext) : DIV_W'(rem_shift);
            lsb_next  = 1'b0;
            q_next    = q_step;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                priority if (zero_reg) begin
                    quot_next = '0;
                end else if (ovf_reg || q_step > RATIO_FULL) begin
                    quot_next = RATIO_FULL;
                end else begin
                    quot_next = q_step;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
        lsb_reg  <= lsb_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

[src/sos_dp.sv]
`default_nettype none
module sos_dp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  sos_pkg::cmd_t                       cmd,
    output sos_pkg::sts_t                       sts,
    input  wire                                 cfg_valid,
    input  wire [sos_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [sos_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                 s_pixel_set,
    input  wire                                 s_row_end,
    input  wire                                 s_frame_end,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [sos_pkg::SPEED_W-1:0]         m_linear_speed,
    output logic signed [sos_pkg::ANG_W-1:0]    m_angular_speed,
    output logic                                m_blocked_flag,
    output logic [sos_pkg::RATIO_W-1:0]         m_left_ratio,
    output logic [sos_pkg::RATIO_W-1:0]         m_center_ratio,
    output logic [sos_pkg::RATIO_W-1:0]         m_right_ratio
);
    import sos_pkg::*;

    // configuration registers
    logic [ROI_W-1:0]   roi_width_reg;
    logic [SPEED_W-1:0] forward_speed_reg, crawl_speed_reg, yaw_limit_reg;
    logic [GAIN_W-1:0]  steer_gain_reg;
    logic [LEVEL_W-1:0] center_stop_reg, side_slow_reg, clear_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_width_reg     <= RST_ROI_WIDTH;
            forward_speed_reg <= RST_FORWARD_SPEED;
            crawl_speed_reg   <= RST_CRAWL_SPEED;
            yaw_limit_reg     <= RST_YAW_LIMIT;
            steer_gain_reg    <= RST_STEER_GAIN;
            center_stop_reg   <= RST_CENTER_STOP;
            side_slow_reg     <= RST_SIDE_SLOW;
            clear_margin_reg  <= RST_CLEAR_MARGIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROI_WIDTH:     roi_width_reg     <= cfg_data[ROI_W-1:0];
                REG_FORWARD_SPEED: forward_speed_reg <= cfg_data[SPEED_W-1:0];
                REG_CRAWL_SPEED:   crawl_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_YAW_LIMIT:     yaw_limit_reg     <= cfg_data[SPEED_W-1:0];
                REG_STEER_GAIN:    steer_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_CENTER_STOP:   center_stop_reg   <= cfg_data[LEVEL_W-1:0];
                REG_SIDE_SLOW:     side_slow_reg     <= cfg_data[LEVEL_W-1:0];
                REG_CLEAR_MARGIN:  clear_margin_reg  <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // sector geometry from the row width
    logic [COL_W-1:0]    w_eff, p_raw, p_sec, sw0, sw1, sw2, rest0, bound1, sw_sel;
    logic [DIV3_P_W-1:0] p_full;

    always_comb begin
        priority if (roi_width_reg == '0) begin
            w_eff = COL_W'(1);
        end else if (WCMP_W'(roi_width_reg) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(roi_width_reg);
        end
        p_full = DIV3_P_W'(w_eff) * DIV3_P_W'(DIV3_MUL);
        p_raw  = COL_W'(p_full >> DIV3_SH);
        p_sec  = (p_raw == '0) ? COL_W'(1) : p_raw;
        sw0    = (p_sec < w_eff) ? p_sec : w_eff;
        rest0  = w_eff - sw0;
        sw1    = (p_sec < rest0) ? p_sec : rest0;
        bound1 = sw0 + sw1;
        sw2    = w_eff - bound1;
        unique case (cmd.sector)
            SEC_LEFT:   sw_sel = sw0;
            SEC_CENTER: sw_sel = sw1;
            default:    sw_sel = sw2;
        endcase
    end

    // pixel accumulation
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] rows_reg;
    logic [CNT_W-1:0] cnt_reg [3];
    logic             in_roi;
    logic             row_done;
    sector_t          pix_sector;

    always_comb begin
        in_roi   = (col_reg < w_eff) && (rows_reg < ROW_W'(MAX_ROWS));
        row_done = s_row_end || s_frame_end;
        priority if (col_reg < sw0) begin
            pix_sector = SEC_LEFT;
        end else if (col_reg < bound1) begin
            pix_sector = SEC_CENTER;
        end else begin
            pix_sector = SEC_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            col_reg  <= '0;
            rows_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cmd.accept) begin
            if (s_pixel_set && in_roi && cnt_reg[pix_sector] != CNT_MAX) begin
                cnt_reg[pix_sector] <= cnt_reg[pix_sector] + CNT_W'(1);
            end
            if (row_done) begin
                col_reg <= '0;
                if (rows_reg < ROW_W'(MAX_ROWS)) begin
                    rows_reg <= rows_reg + ROW_W'(1);
                end
            end else if (col_reg < w_eff) begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // sector area and count staging for the divider
    logic [AREA_W-1:0] area_reg;
    logic [CNT_W-1:0]  dcount_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_area) begin
            area_reg   <= AREA_W'(sw_sel) * AREA_W'(rows_reg);
            dcount_reg <= cnt_reg[cmd.sector];
        end
    end

    logic               div_done;
    logic [RATIO_W-1:0] div_quot;

    sos_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .count   (dcount_reg),
        .area    (area_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    logic [RATIO_W-1:0] ratio_reg [3];

    always_ff @(posedge aclk) begin
        if (cmd.store_ratio) begin
            ratio_reg[cmd.sector] <= div_quot;
        end
    end

    // decision, first step: threshold, side test, steering product
    logic signed [LEVEL_W:0]  thr_raw, thr;
    logic signed [DIFF_W-1:0] diff;
    logic                     blocked_reg, side_reg, was_blocked_reg;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb begin
        thr_raw = $signed({1'b0, center_stop_reg}) - $signed({1'b0, clear_margin_reg});
        if (was_blocked_reg) begin
            thr = (thr_raw < $signed(MIN_STOP_LEVEL)) ? $signed(MIN_STOP_LEVEL) : thr_raw;
        end else begin
            thr = $signed({1'b0, center_stop_reg});
        end
        diff = $signed({1'b0, ratio_reg[0]}) - $signed({1'b0, ratio_reg[2]});
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            blocked_reg <= $signed({1'b0, ratio_reg[1]}) >= thr;
            side_reg    <= (ratio_reg[0] >= side_slow_reg) || (ratio_reg[2] >= side_slow_reg);
            prod_reg    <= PROD_W'(diff) * $signed(PROD_W'({1'b0, steer_gain_reg}));
        end
    end

    // decision, second step: speeds
    logic signed [STEER_W-1:0] steer, turn_s, steer_c, ang_full;
    logic [SPEED_W-1:0]        lin;

    always_comb begin
        steer  = prod_reg[PROD_W-1:STEER_SH];
        turn_s = $signed(STEER_W'(yaw_limit_reg));
        priority if (steer > turn_s) begin
            steer_c = turn_s;
        end else if (steer < -turn_s) begin
            steer_c = -turn_s;
        end else begin
            steer_c = steer;
        end
        priority if (blocked_reg) begin
            lin      = '0;
            ang_full = (ratio_reg[0] < ratio_reg[2]) ? turn_s : -turn_s;
        end else if (side_reg) begin
            lin      = crawl_speed_reg;
            ang_full = -steer_c;
        end else begin
            lin      = forward_speed_reg;
            ang_full = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_blocked_reg <= 1'b0;
        end else if (cmd.finish) begin
            was_blocked_reg <= blocked_reg;
        end
    end

    // output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            m_linear_speed  <= lin;
            m_angular_speed <= ang_full[ANG_W-1:0];
            m_blocked_flag  <= blocked_reg;
            m_left_ratio    <= ratio_reg[0];
            m_center_ratio  <= ratio_reg[1];
            m_right_ratio   <= ratio_reg[2];
        end
    end

    assign m_valid      = m_valid_reg;
    assign sts.div_done = div_done;
    assign sts.out_busy = m_valid_reg && !m_ready;

    a_clear_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (col_reg == '0 && rows_reg == '0 && cnt_reg[0] == '0
                        && cnt_reg[1] == '0 && cnt_reg[2] == '0))
        else $error("frame state not cleared after result");

    a_blocked_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_blocked_flag) |-> m_linear_speed == '0)
        else $error("blocked frame with nonzero linear speed");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_left_ratio <= RATIO_FULL && m_center_ratio <= RATIO_FULL
                         && m_right_ratio <= RATIO_FULL))
        else $error("occupancy ratio above full scale");

endmodule
`default_nettype wire

[src/sos_ctrl.sv]
`default_nettype none
module sos_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_frame_end,
    input  sos_pkg::sts_t      sts,
    output sos_pkg::cmd_t      cmd
);
    import sos_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_AREA    = 6'b000010,
        ST_DIVGO   = 6'b000100,
        ST_DIVWAIT = 6'b001000,
        ST_DEC1    = 6'b010000,
        ST_DEC2    = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    sector_t sector_reg, sector_next;

    always_comb begin
        state_next      = state_reg;
        sector_next     = sector_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.sector      = sector_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_frame_end) begin
                    state_next  = ST_AREA;
                    sector_next = SEC_LEFT;
                end
            end
            ST_AREA: begin
                cmd.load_area = 1'b1;
                state_next    = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (sts.div_done) begin
                    cmd.store_ratio = 1'b1;
                    if (sector_reg == SEC_RIGHT) begin
                        state_next = ST_DEC1;
                    end else begin
                        sector_next = sector_reg + 2'd1;
                        state_next  = ST_AREA;
                    end
                end
            end
            ST_DEC1: begin
                cmd.decide = 1'b1;
                state_next = ST_DEC2;
            end
            ST_DEC2: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sector_reg <= SEC_LEFT;
        end else begin
            state_reg  <= state_next;
            sector_reg <= sector_next;
        end
    end

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == ST_DIVWAIT)
        else $error("divider finished outside its wait state");

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sector_reg == SEC_LEFT || sector_reg == SEC_CENTER || sector_reg == SEC_RIGHT)
        else $error("sector index out of range");

    a_result_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (state_reg == ST_IDLE && s_ready))
        else $error("pixel input not reopened after result");

endmodule
`default_nettype wire

[src/sector_occupancy_steering.sv]
`default_nettype none
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------------------
// s_       | in        | s_valid / s_ready      | pixel_set, row_end, frame_end
// m_       | out       | m_valid / m_ready      | linear_speed, angular_speed, blocked_flag,
//          |           |                        | left/center/right_ratio
// cfg_     | in        | cfg_valid / cfg_ready  | cfg_index (4b), cfg_data (17b)
//
// one pixel beat per cycle; pixels stream back to back inside a frame
// the frame-end beat starts a sequencer: three sector divides on one shared
// restoring divider, then the decision states DEC1 and DEC2, before the pixel
// input opens again
// the result waits in an output register; the next frame's pixels are taken
// meanwhile; after a following frame end the sequencer stalls while it is unread
// synchronous active-low reset; configuration writes are always accepted
module sector_occupancy_steering (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write channel
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [sos_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [sos_pkg::CFG_DATA_W-1:0]       cfg_data,
    // mask pixel stream
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_pixel_set,
    input  wire                                 s_row_end,
    input  wire                                 s_frame_end,
    // steering result
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [sos_pkg::SPEED_W-1:0]         m_linear_speed,
    output logic signed [sos_pkg::ANG_W-1:0]    m_angular_speed,
    output logic                                m_blocked_flag,
    output logic [sos_pkg::RATIO_W-1:0]         m_left_ratio,
    output logic [sos_pkg::RATIO_W-1:0]         m_center_ratio,
    output logic [sos_pkg::RATIO_W-1:0]         m_right_ratio
);
    import sos_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register file never stalls a write
    assign cfg_ready = 1'b1;

    // sequencer: pixel intake, divide loop over the sectors, decision, result
    sos_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame_end (s_frame_end),
        .sts         (sts),
        .cmd         (cmd)
    );

    // counters, config registers, divider, steering math and output register
    sos_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_pixel_set     (s_pixel_set),
        .s_row_end       (s_row_end),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_linear_speed  (m_linear_speed),
        .m_angular_speed (m_angular_speed),
        .m_blocked_flag  (m_blocked_flag),
        .m_left_ratio    (m_left_ratio),
        .m_center_ratio  (m_center_ratio),
        .m_right_ratio   (m_right_ratio)
    );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import sos_pkg::*;

    // one steering command as it leaves the result channel
    typedef struct packed {
        logic [SPEED_W-1:0] linear;
        logic [ANG_W-1:0]   angular;
        logic               blocked;
        logic [RATIO_W-1:0] left_r;
        logic [RATIO_W-1:0] center_r;
        logic [RATIO_W-1:0] right_r;
    } steer_cmd_t;

    localparam int NUM_REGS   = int'(REG_CLEAR_MARGIN) + 1;
    localparam int SETTLE     = 80;     // idle wait after the frame-end sequencer
    localparam int BEAT_GOAL  = 1750;
    localparam int HOLD_LEN   = 300;

    // keeps a copy of the frame counters and registers, predicts the
    // steering command of every frame and checks what comes out
    class steering_tracker;
        logic [ROI_W-1:0]   roi_width;
        logic [SPEED_W-1:0] fwd_speed, crawl_speed, yaw_limit;
        logic [GAIN_W-1:0]  steer_gain;
        logic [LEVEL_W-1:0] stop_level, slow_level, margin;

        int unsigned col_pos, row_tally;
        int unsigned sector_hits[3];
        bit          last_blocked;

        steer_cmd_t pending_cmds[$];
        int errors, cmds_checked;

        function new();
            roi_width   = RST_ROI_WIDTH;
            fwd_speed   = RST_FORWARD_SPEED;
            crawl_speed = RST_CRAWL_SPEED;
            yaw_limit   = RST_YAW_LIMIT;
            steer_gain  = RST_STEER_GAIN;
            stop_level  = RST_CENTER_STOP;
            slow_level  = RST_SIDE_SLOW;
            margin      = RST_CLEAR_MARGIN;
            col_pos = 0;
            row_tally = 0;
            sector_hits = '{0, 0, 0};
            last_blocked = 0;
            errors = 0;
            cmds_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROI_WIDTH:     roi_width   = data[ROI_W-1:0];
                REG_FORWARD_SPEED: fwd_speed   = data[SPEED_W-1:0];
                REG_CRAWL_SPEED:   crawl_speed = data[SPEED_W-1:0];
                REG_YAW_LIMIT:     yaw_limit   = data[SPEED_W-1:0];
                REG_STEER_GAIN:    steer_gain  = data[GAIN_W-1:0];
                REG_CENTER_STOP:   stop_level  = data[LEVEL_W-1:0];
                REG_SIDE_SLOW:     slow_level  = data[LEVEL_W-1:0];
                REG_CLEAR_MARGIN:  margin      = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted pixel beat; on a frame end the expected command is queued
        function void take_pixel(bit pix, bit rend, bit fend);
            int unsigned w, p, k;
            int unsigned sw[3];
            longint area, thr, diff, steer, lim, ang;
            longint ratio[3];
            bit blocked;
            steer_cmd_t cmd;
            w = (roi_width == 0) ? 1 : (roi_width > MAX_WIDTH) ? MAX_WIDTH : roi_width;
            p = (w / 3 < 1) ? 1 : w / 3;
            sw[SEC_LEFT]   = (p < w) ? p : w;
            sw[SEC_CENTER] = (p < w - sw[SEC_LEFT]) ? p : w - sw[SEC_LEFT];
            sw[SEC_RIGHT]  = w - sw[SEC_LEFT] - sw[SEC_CENTER];

            // pixels past the row width or past the last counted row drop out
            if (pix && col_pos < w && row_tally < MAX_ROWS) begin
                k = (col_pos < sw[SEC_LEFT]) ? SEC_LEFT
                  : (col_pos < sw[SEC_LEFT] + sw[SEC_CENTER]) ? SEC_CENTER : SEC_RIGHT;
                if (sector_hits[k] < CNT_MAX) sector_hits[k]++;
            end
            if (col_pos < w) col_pos++;
            if (rend || fend) begin
                col_pos = 0;
                if (row_tally < MAX_ROWS) row_tally++;
            end
            if (!fend) return;

            // short rows still count as full rows in the area
            for (int s = 0; s < 3; s++) begin
                area = longint'(sw[s]) * longint'(row_tally);
                ratio[s] = (area == 0) ? 0 : (longint'(sector_hits[s]) << 16) / area;
                if (ratio[s] > longint'(RATIO_FULL)) ratio[s] = longint'(RATIO_FULL);
            end

            // hysteresis: after a blocked frame the stop level drops, with a floor
            thr = longint'(stop_level);
            if (last_blocked) begin
                thr = longint'(stop_level) - longint'(margin);
                if (thr < longint'(MIN_STOP_LEVEL)) thr = longint'(MIN_STOP_LEVEL);
            end
            blocked = (ratio[SEC_CENTER] >= thr);
            lim = longint'(yaw_limit);

            if (blocked) begin
                cmd.linear = '0;
                ang = (ratio[SEC_LEFT] < ratio[SEC_RIGHT]) ? lim : -lim;
            end else if (ratio[SEC_LEFT] >= longint'(slow_level) ||
                         ratio[SEC_RIGHT] >= longint'(slow_level)) begin
                cmd.linear = crawl_speed;
                diff = ratio[SEC_LEFT] - ratio[SEC_RIGHT];
                steer = (diff * longint'(steer_gain)) >>> 18;   // floor toward -inf
                if (steer > lim) steer = lim;
                if (steer < -lim) steer = -lim;
                ang = -steer;
            end else begin
                cmd.linear = fwd_speed;
                ang = 0;
            end
            last_blocked = blocked;

            cmd.angular  = ang[ANG_W-1:0];
            cmd.blocked  = blocked;
            cmd.left_r   = ratio[SEC_LEFT][RATIO_W-1:0];
            cmd.center_r = ratio[SEC_CENTER][RATIO_W-1:0];
            cmd.right_r  = ratio[SEC_RIGHT][RATIO_W-1:0];
            pending_cmds.push_back(cmd);

            col_pos = 0;
            row_tally = 0;
            sector_hits = '{0, 0, 0};
        endfunction

        function void take_command(steer_cmd_t got);
            steer_cmd_t want;
            cmds_checked++;
            if (pending_cmds.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: steering command with no frame pending at %0t", $realtime);
                return;
            end
            want = pending_cmds.pop_front();
            if (got.linear != want.linear || got.angular != want.angular ||
                got.blocked != want.blocked || got.left_r != want.left_r ||
                got.center_r != want.center_r || got.right_r != want.right_r) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at %0t: exp lin %0d ang %0d blk %0b ratios %0d %0d %0d",
                             $realtime, want.linear, $signed(want.angular), want.blocked,
                             want.left_r, want.center_r, want.right_r);
                    $display("                 got lin %0d ang %0d blk %0b ratios %0d %0d %0d",
                             got.linear, $signed(got.angular), got.blocked,
                             got.left_r, got.center_r, got.right_r);
                end
            end
        endfunction

        function int fails();
            return errors + pending_cmds.size();
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // pixel stream
    logic s_valid     = 1'b0;
    logic s_ready;
    logic s_pixel_set = 1'b0;
    logic s_row_end   = 1'b0;
    logic s_frame_end = 1'b0;

    // command stream
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [SPEED_W-1:0]        m_linear_speed;
    logic signed [ANG_W-1:0]   m_angular_speed;
    logic                      m_blocked_flag;
    logic [RATIO_W-1:0]        m_left_ratio, m_center_ratio, m_right_ratio;

    steering_tracker tracker = new();

    // pacing knobs, percent per cycle
    int src_idle_pct = 0;
    int stall_pct    = 0;
    int hold_req     = 0;    // long receiver hold-off, picked up by the sink process
    int hold_left    = 0;
    int beats_sent   = 0;

    logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];

    // roi widths of the first phases: extremes, narrow rows, clamped values
    int w_list [8] = '{2047, 1, 2, 0, 3, 1024, 1500, 5};

    sector_occupancy_steering u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_set     (s_pixel_set),
        .s_row_end       (s_row_end),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_linear_speed  (m_linear_speed),
        .m_angular_speed (m_angular_speed),
        .m_blocked_flag  (m_blocked_flag),
        .m_left_ratio    (m_left_ratio),
        .m_center_ratio  (m_center_ratio),
        .m_right_ratio   (m_right_ratio)
    );

    always #1 aclk = ~aclk;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("testbench: errors");
        $finish;
    end

    // sink: check the beat taken at this edge, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.take_command(steer_cmd_t'{m_linear_speed, m_angular_speed, m_blocked_flag,
                                              m_left_ratio, m_center_ratio, m_right_ratio});
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // random value with the ends of the range favored
    function automatic int unsigned pick(int unsigned hi);
        case ($urandom_range(5))
            0: return 0;
            1: return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    // Q1.16 level: zero, full scale, random up to full scale, or above it where it never fires
    function automatic int unsigned pick_level();
        case ($urandom_range(7))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(65537, 131071);
            default: return $urandom_range(65536);
        endcase
    endfunction

    // one pixel beat; optional idle cycles in front, valid held until taken
    task automatic send_beat(input bit pix, input bit rend, input bit fend);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_pixel_set <= pix;
        s_row_end   <= rend;
        s_frame_end <= fend;
        do @(posedge aclk); while (!s_ready);
        tracker.take_pixel(pix, rend, fend);
        beats_sent++;
    endtask

    // fixed row pattern, bit c is column c; end marks on the last beat
    task automatic send_row(input int len, input logic [15:0] pix,
                            input bit rend, input bit fend);
        for (int c = 0; c < len; c++)
            send_beat(pix[c], (c == len - 1) && rend, (c == len - 1) && fend);
    endtask

    // sender goes quiet until every frame has produced its command
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_cmds.size() != 0);
    endtask

    task automatic program_regs();
        for (int i = int'(REG_ROI_WIDTH); i <= int'(REG_CLEAR_MARGIN); i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= reg_plan[i];
            do @(posedge aclk); while (!cfg_ready);
            tracker.set_reg(CFG_IDX_W'(i), reg_plan[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int w_eff, p, rows_n, len, n_frames;
        int dens [3];
        bit open_end, pix;

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // --- directed part ---

        // reset values: one short row closed by a frame end without a row end
        send_row(3, 16'b111, 1'b0, 1'b1);
        drain();
        repeat (SETTLE) @(posedge aclk);

        // six-pixel rows, forward speed zero, other speeds and gain at full scale, no hysteresis margin
        reg_plan[REG_ROI_WIDTH]     = 6;
        reg_plan[REG_FORWARD_SPEED] = 0;
        reg_plan[REG_CRAWL_SPEED]   = 4095;
        reg_plan[REG_YAW_LIMIT]     = 4095;
        reg_plan[REG_STEER_GAIN]    = 16383;
        reg_plan[REG_CENTER_STOP]   = 32768;
        reg_plan[REG_SIDE_SLOW]     = 16384;
        reg_plan[REG_CLEAR_MARGIN]  = 0;
        program_regs();

        // all set: blocked, left and right tie so it turns right
        send_row(6, 16'b111111, 1'b1, 1'b1);
        // right side only, second row too long: slow with clamped steering
        send_row(6, 16'b110000, 1'b1, 1'b0);
        send_row(7, 16'b1110000, 1'b1, 1'b1);
        // centre and right full: blocked, turn toward the clear left
        send_row(6, 16'b111100, 1'b1, 1'b1);

        // --- random phases ---
        for (int ph = 0; ph < 4 || beats_sent < BEAT_GOAL; ph++) begin
            // registers change only with the block idle
            drain();
            repeat (SETTLE) @(posedge aclk);

            // pacing cycles: none, sender idle, receiver stall, both light
            case (ph % 4)
                0: begin src_idle_pct = 0;  stall_pct = 0;  end
                1: begin src_idle_pct = 72; stall_pct = 0;  end
                2: begin src_idle_pct = 0;  stall_pct = 72; end
                default: begin src_idle_pct = 16; stall_pct = 16; end
            endcase

            if (ph < 8)
                reg_plan[REG_ROI_WIDTH] = CFG_DATA_W'(w_list[ph]);
            else
                case ($urandom_range(9))
                    0: reg_plan[REG_ROI_WIDTH] = CFG_DATA_W'($urandom_range(65, 2047));
                    1, 2: reg_plan[REG_ROI_WIDTH] = CFG_DATA_W'($urandom_range(13, 64));
                    default: reg_plan[REG_ROI_WIDTH] = CFG_DATA_W'($urandom_range(1, 12));
                endcase
            reg_plan[REG_FORWARD_SPEED] = CFG_DATA_W'(pick(4095));
            reg_plan[REG_CRAWL_SPEED]   = CFG_DATA_W'(pick(4095));
            reg_plan[REG_YAW_LIMIT]     = CFG_DATA_W'(pick(4095));
            reg_plan[REG_STEER_GAIN]    = CFG_DATA_W'(pick(16383));
            reg_plan[REG_CENTER_STOP]   = CFG_DATA_W'(pick_level());
            reg_plan[REG_SIDE_SLOW]     = CFG_DATA_W'(pick_level());
            reg_plan[REG_CLEAR_MARGIN]  = CFG_DATA_W'(pick_level());
            program_regs();

            w_eff = (reg_plan[REG_ROI_WIDTH] == 0) ? 1
                  : (reg_plan[REG_ROI_WIDTH] > MAX_WIDTH) ? MAX_WIDTH
                  : int'(reg_plan[REG_ROI_WIDTH]);
            p = (w_eff / 3 < 1) ? 1 : w_eff / 3;

            // receiver backs off for a long stretch so the result register
            // stays full and the next frame end stalls the pixel input
            if (ph == 2) hold_req = HOLD_LEN;

            n_frames = $urandom_range(4, 10);
            for (int f = 0; f < n_frames; f++) begin
                // per-sector fill density: empty, full or random
                foreach (dens[s])
                    case ($urandom_range(3))
                        0: dens[s] = 0;
                        1: dens[s] = 100;
                        default: dens[s] = $urandom_range(100);
                    endcase
                rows_n = (w_eff > 64) ? 1 : $urandom_range(1, 6);
                open_end = ($urandom_range(3) == 0);
                for (int r = 0; r < rows_n; r++) begin
                    // mostly full rows, some short or too long; above 64 wide mostly short rows
                    if (w_eff > 64)
                        len = ($urandom_range(7) == 0) ? $urandom_range(p, w_eff)
                                                       : $urandom_range(1, 24);
                    else
                        case ($urandom_range(9))
                            0: len = $urandom_range(1, w_eff);
                            1: len = w_eff + $urandom_range(1, 4);
                            default: len = w_eff;
                        endcase
                    for (int c = 0; c < len; c++) begin
                        pix = ($urandom_range(99) < dens[(c < p) ? 0 : (c < 2 * p) ? 1 : 2]);
                        send_beat(pix, (c == len - 1) && !(r == rows_n - 1 && open_end),
                                  (c == len - 1) && (r == rows_n - 1));
                    end
                end
                if (f == n_frames / 2) drain();
            end

            // mostly one-pixel rows past the row limit: the row counter saturates
            if (ph == 1)
                for (int r = 0; r < MAX_ROWS + 6; r++) begin
                    len = ($urandom_range(7) == 0) ? 2 : 1;
                    for (int c = 0; c < len; c++)
                        send_beat(1'($urandom_range(1)), c == len - 1,
                                  (c == len - 1) && (r == MAX_ROWS + 5));
                end
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (tracker.fails() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
